// File: rtl/masked_integral_image_sum_square_top_defines.svh
// Assertion macros shared by the masked integral image block.
`ifndef MASKED_INTEGRAL_IMAGE_SUM_SQUARE_TOP_DEFINES_SVH
`define MASKED_INTEGRAL_IMAGE_SUM_SQUARE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MISQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/misq_pkg.sv
// Package with shared constants and types of the masked integral image block.
`default_nettype none
package misq_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int LEN_W       = COL_W + 1;
  localparam int PIX_W       = 8;
  localparam int PIX_SQ_W    = 2 * PIX_W;
  localparam int ROW_CNT_W   = 11;
  localparam int ROW_SUM_W   = 18;
  localparam int ROW_SQ_W    = 26;
  localparam int CNT_W       = 21;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 36;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0]  REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_USE_MASK   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ROW_LENGTH_RST = CFG_DATA_W'(MAX_WIDTH);

  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic                 first_row;
    logic [ROW_CNT_W-1:0] row_cnt;
    logic [ROW_SUM_W-1:0] row_sum;
    logic [ROW_SQ_W-1:0]  row_sq;
  } misq_job_t;

  typedef struct packed {
    logic [CNT_W-1:0] valid_count;
    logic [SUM_W-1:0] pixel_sum;
    logic [SQ_W-1:0]  square_sum;
  } misq_res_t;

  localparam int RES_W = $bits(misq_res_t);

endpackage
`default_nettype wire

// File: rtl/misq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module misq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/misq_front.sv
// Front end: configuration registers, column tracking and running row sums.
`default_nettype none
module misq_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [misq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [misq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_push,
  input  wire logic [misq_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic                            in_valid_mask,
  input  wire logic                            in_start_of_frame,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output misq_pkg::misq_job_t                  q_job
);
  import misq_pkg::*;

  logic [CFG_DATA_W-1:0] row_length_r;
  logic                  use_mask_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic                  first_r, first_nxt;
  logic [ROW_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROW_SUM_W-1:0]  sum_r, sum_nxt;
  logic [ROW_SQ_W-1:0]   sq_r, sq_nxt;

  logic [COL_W-1:0]      col_cur;
  logic                  first_cur;
  logic [ROW_CNT_W-1:0]  cnt_cur;
  logic [ROW_SUM_W-1:0]  sum_cur;
  logic [ROW_SQ_W-1:0]   sq_cur;
  logic                  counted;
  logic [PIX_SQ_W-1:0]   pix_sq;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      col_inc;
  logic                  row_end;

  assign cfg_ready = 1'b1;
  assign q_push    = in_push && !q_full;

  always_comb begin
    if (in_start_of_frame) begin
      col_cur   = '0;
      first_cur = 1'b1;
      cnt_cur   = '0;
      sum_cur   = '0;
      sq_cur    = '0;
    end else begin
      col_cur   = col_r;
      first_cur = first_r;
      cnt_cur   = cnt_r;
      sum_cur   = sum_r;
      sq_cur    = sq_r;
    end
    counted = !use_mask_r || in_valid_mask;
    pix_sq  = PIX_SQ_W'(in_pixel) * PIX_SQ_W'(in_pixel);

    q_job.col       = col_cur;
    q_job.first_row = first_cur;
    q_job.row_cnt   = counted ? cnt_cur + ROW_CNT_W'(1) : cnt_cur;
    q_job.row_sum   = counted ? sum_cur + ROW_SUM_W'(in_pixel) : sum_cur;
    q_job.row_sq    = counted ? sq_cur + ROW_SQ_W'(pix_sq) : sq_cur;

    if (row_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (row_length_r > CFG_DATA_W'(MAX_WIDTH)) begin
      len_eff = LEN_W'(MAX_WIDTH);
    end else begin
      len_eff = LEN_W'(row_length_r);
    end
    col_inc = LEN_W'(col_cur) + LEN_W'(1);
    row_end = col_inc >= len_eff;

    col_nxt   = col_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    if (q_push) begin
      col_nxt   = row_end ? '0 : col_inc[COL_W-1:0];
      first_nxt = row_end ? 1'b0 : first_cur;
      cnt_nxt   = row_end ? '0 : q_job.row_cnt;
      sum_nxt   = row_end ? '0 : q_job.row_sum;
      sq_nxt    = row_end ? '0 : q_job.row_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      use_mask_r   <= 1'b1;
      col_r        <= '0;
      first_r      <= 1'b1;
      cnt_r        <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROW_LENGTH: begin
            row_length_r <= cfg_data;
          end
          REG_USE_MASK: begin
            use_mask_r <= cfg_data[0];
          end
        endcase
      end
      col_r   <= col_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/misq_queue.sv
// Short queue of classified pixel jobs between the front and back ends.
`default_nettype none
module misq_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire misq_pkg::misq_job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output misq_pkg::misq_job_t pop_job,
  output logic               empty
);
  import misq_pkg::*;

  misq_job_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/misq_back.sv
// Back end: line store lookup, saturating integral update and result queue.
`default_nettype none
module misq_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire misq_pkg::misq_job_t        q_job,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [misq_pkg::CNT_W-1:0]      out_valid_count,
  output logic [misq_pkg::SUM_W-1:0]      out_pixel_sum,
  output logic [misq_pkg::SQ_W-1:0]       out_square_sum
);
  import misq_pkg::*;

  misq_job_t         stage_r;
  logic              stage_v_r;
  logic              fwd_v_r;
  logic [COL_W-1:0]  fwd_col_r;
  misq_res_t         fwd_data_r;
  logic [RES_W-1:0]  ram_rdata;
  misq_res_t         base;
  misq_res_t         res;
  logic [CNT_W:0]    cnt_add;
  logic [SUM_W:0]    sum_add;
  logic [SQ_W:0]     sq_add;

  misq_res_t         ofifo_r [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [OPTR_W-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [OCNT_W-1:0] ocount_r, ocount_nxt;
  logic              o_pop;
  misq_res_t         o_head;

  assign q_pop = !q_empty &&
                 ((ocount_r + OCNT_W'(stage_v_r)) < OCNT_W'(OUT_DEPTH));

  misq_ram #(
    .WIDTH (RES_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (stage_v_r),
    .wr_addr (stage_r.col),
    .wr_data (res),
    .rd_addr (q_job.col),
    .rd_data (ram_rdata)
  );

  always_comb begin
    if (fwd_v_r && (fwd_col_r == stage_r.col)) begin
      base = fwd_data_r;
    end else begin
      base = misq_res_t'(ram_rdata);
    end
    cnt_add = CNT_W'(stage_r.row_cnt) + (CNT_W + 1)'(base.valid_count);
    sum_add = SUM_W'(stage_r.row_sum) + (SUM_W + 1)'(base.pixel_sum);
    sq_add  = SQ_W'(stage_r.row_sq) + (SQ_W + 1)'(base.square_sum);
    if (stage_r.first_row) begin
      res.valid_count = CNT_W'(stage_r.row_cnt);
      res.pixel_sum   = SUM_W'(stage_r.row_sum);
      res.square_sum  = SQ_W'(stage_r.row_sq);
    end else begin
      res.valid_count = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
      res.pixel_sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      res.square_sum  = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stage_r <= q_job;
    end
    fwd_col_r  <= stage_r.col;
    fwd_data_r <= res;
    if (stage_v_r) begin
      ofifo_r[owr_ptr_r] <= res;
    end
  end

  assign o_pop           = out_pop && !out_empty;
  assign out_empty       = ocount_r == '0;
  assign o_head          = ofifo_r[ord_ptr_r];
  assign out_valid_count = o_head.valid_count;
  assign out_pixel_sum   = o_head.pixel_sum;
  assign out_square_sum  = o_head.square_sum;

  always_comb begin
    owr_ptr_nxt = stage_v_r ? owr_ptr_r + OPTR_W'(1) : owr_ptr_r;
    ord_ptr_nxt = o_pop ? ord_ptr_r + OPTR_W'(1) : ord_ptr_r;
    ocount_nxt  = ocount_r + OCNT_W'(stage_v_r) - OCNT_W'(o_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      fwd_v_r   <= 1'b0;
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocount_r  <= '0;
    end else begin
      stage_v_r <= q_pop;
      fwd_v_r   <= stage_v_r;
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocount_r  <= ocount_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/masked_integral_image_sum_square_top.sv
// Top level of the masked integral image block with count, sum and square sums.
`default_nettype none
`include "masked_integral_image_sum_square_top_defines.svh"
// The block takes one pixel word per clock while in_full is low and returns
// one result word per pixel, in order, with the count, sum and sum of squares
// of the counted pixels in the rectangle from the frame origin to that
// position. A result passes through the job queue, the stage register and the
// result queue before it appears. The rate is set by the line store, which has
// one read port and one write port and is read and written once per pixel, and
// by a bypass register that covers a read of a column written in the same
// cycle. The line store needs no clearing after reset: its read data is only
// used on rows after the first of a frame. The user must write the registers
// only while no pixel is in flight; the block itself does not enforce this.
module masked_integral_image_sum_square_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [misq_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic                            in_valid_mask,
  input  wire logic                            in_start_of_frame,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [misq_pkg::CNT_W-1:0]           out_valid_count,
  output logic [misq_pkg::SUM_W-1:0]           out_pixel_sum,
  output logic [misq_pkg::SQ_W-1:0]            out_square_sum,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [misq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [misq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import misq_pkg::*;

  logic      q_push;
  misq_job_t q_push_job;
  logic      q_full;
  logic      q_pop;
  misq_job_t q_pop_job;
  logic      q_empty;

  assign in_full = q_full;

  misq_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_pixel          (in_pixel),
    .in_valid_mask     (in_valid_mask),
    .in_start_of_frame (in_start_of_frame),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (q_push_job)
  );

  misq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  misq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_job           (q_pop_job),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_valid_count (out_valid_count),
    .out_pixel_sum   (out_pixel_sum),
    .out_square_sum  (out_square_sum)
  );

  `MISQ_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "job popped from an empty queue")
  `MISQ_ASSERT_NOW(a_full_not_empty, q_full, !q_empty, "job queue both full and empty")
  `MISQ_ASSERT_NEXT(a_push_lands, q_push && q_empty, !q_empty, "accepted pixel lost")

endmodule
`default_nettype wire
